// ===== src/rat_pkg.sv =====
// Ride activity tracker package: payload types, ride state codes, event kinds
// and configuration register indexes. No dependencies.
`default_nettype none
package rat_pkg;

  typedef logic [1:0]  kind_t;
  typedef logic [1:0]  ride_state_t;
  typedef logic [15:0] speed_t;
  typedef logic [15:0] count16_t;
  typedef logic [7:0]  count8_t;
  typedef logic [2:0]  cfg_index_t;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SUM_W      = 32;

  localparam ride_state_t ST_NOT_STARTED = 2'd0;
  localparam ride_state_t ST_ACTIVE      = 2'd1;
  localparam ride_state_t ST_IDLE        = 2'd2;
  localparam ride_state_t ST_PAUSED      = 2'd3;

  localparam kind_t KIND_TICK  = 2'd0;
  localparam kind_t KIND_START = 2'd1;
  localparam kind_t KIND_PAUSE = 2'd2;
  localparam kind_t KIND_STOP  = 2'd3;

  localparam cfg_index_t CFG_AUTO_START     = 3'd0;
  localparam cfg_index_t CFG_AUTO_PAUSE     = 3'd1;
  localparam cfg_index_t CFG_AUTO_RESUME    = 3'd2;
  localparam cfg_index_t CFG_IDLE_SPEED     = 3'd3;
  localparam cfg_index_t CFG_IDLE_TIMEOUT   = 3'd4;
  localparam cfg_index_t CFG_PAUSE_TIMEOUT  = 3'd5;
  localparam cfg_index_t CFG_RESUME_TIMEOUT = 3'd6;
  localparam cfg_index_t CFG_TOP_DELTA      = 3'd7;

  localparam count16_t DURATION_MAX = 16'hFFFF;

endpackage
`default_nettype wire

// ===== src/rat_if.sv =====
// Ride activity tracker channel interfaces (input events, result records).
// Depends on rat_pkg.
`default_nettype none
interface rat_in_if;
  logic               valid;
  logic               ready;
  rat_pkg::kind_t     kind;
  rat_pkg::speed_t    speed;
  logic               speed_valid;

  modport source (output valid, kind, speed, speed_valid, input ready);
  modport sink   (input valid, kind, speed, speed_valid, output ready);
endinterface

interface rat_out_if;
  logic                  valid;
  logic                  ready;
  rat_pkg::ride_state_t  ride_state;
  rat_pkg::count16_t     duration;
  rat_pkg::speed_t       average_speed;
  rat_pkg::speed_t       top_speed;
  logic                  distance_reset;
  logic                  log_push;

  modport source (output valid, ride_state, duration, average_speed, top_speed,
                  distance_reset, log_push, input ready);
  modport sink   (input valid, ride_state, duration, average_speed, top_speed,
                  distance_reset, log_push, output ready);
endinterface
`default_nettype wire

// ===== src/ride_activity_tracker.sv =====
// Ride activity tracker top level: ride state machine, serial divider for the
// average speed and serial window scan for top speed. Depends on rat_pkg, rat_if.
//
// Channel   Dir  Handshake        Payload
// in_ch     in   valid/ready      kind, speed, speed_valid
// out_ch    out  valid/ready      ride_state, duration, average_speed, top_speed,
//                                 distance_reset, log_push
// cfg_*     in   cfg_we only      cfg_index, cfg_data
//
// A counted tick runs 32 restoring divide steps of the 32-bit speed sum by the
// duration, with the window scan (one entry a cycle) alongside, after the accept
// step and before the finish and output load steps; events and uncounted ticks
// go straight to output load. One item at a time; in_ch.ready is low while an
// item is in work. The result register frees the input side while a result
// waits; a stalled out_ch holds the next result in the done state. Synchronous
// active-low reset clears configuration, ride and control state, not datapath.
`default_nettype none
module ride_activity_tracker #(
  parameter int unsigned WINDOW_LEN = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  rat_in_if.sink                                 in_ch,
  rat_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire rat_pkg::cfg_index_t               cfg_index,
  input  wire logic [rat_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned IDXW  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned CNTW  = $clog2(rat_pkg::SUM_W);
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(rat_pkg::SUM_W - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // configuration
  logic                  auto_start_r, auto_pause_r, auto_resume_r;
  rat_pkg::speed_t       idle_speed_r, top_delta_r;
  rat_pkg::count8_t      idle_timeout_r, pause_timeout_r, resume_timeout_r;

  // ride state
  rat_pkg::ride_state_t  status_r, status_nxt;
  rat_pkg::count16_t     tick_r, tick_nxt;
  logic [rat_pkg::SUM_W-1:0] sum_r, sum_nxt;
  rat_pkg::speed_t       avg_r, avg_nxt;
  rat_pkg::speed_t       top_r, top_nxt;
  rat_pkg::speed_t       win_r [WINDOW_LEN];
  rat_pkg::speed_t       win_nxt [WINDOW_LEN];
  rat_pkg::count8_t      idle_cnt_r, idle_cnt_nxt;
  rat_pkg::count8_t      pause_cnt_r, pause_cnt_nxt;
  logic                  dist_r, dist_nxt;
  logic                  log_r, log_nxt;
  logic                  run_nxt;
  rat_pkg::speed_t       evict_nxt;

  // sequencer and shared units
  logic [1:0]            seq_r;
  logic [CNTW-1:0]       cnt_r;
  logic [rat_pkg::SUM_W-1:0] dvd_r;
  rat_pkg::speed_t       rem_r;
  rat_pkg::speed_t       quo_r;
  rat_pkg::speed_t       hi_r, lo_r;

  // output register
  logic                  out_valid_r;
  rat_pkg::ride_state_t  o_state_r;
  rat_pkg::count16_t     o_dur_r;
  rat_pkg::speed_t       o_avg_r, o_top_r;
  logic                  o_dist_r, o_log_r;

  logic                  in_xfer, out_xfer, out_load;
  logic [16:0]           rem_sh, rem_sub;
  logic                  q_bit;
  logic                  scan_en;
  rat_pkg::speed_t       win_sel;
  logic [16:0]           spread;

  assign in_ch.ready = (seq_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_valid_r && out_ch.ready;
  assign out_load    = (seq_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid          = out_valid_r;
  assign out_ch.ride_state     = o_state_r;
  assign out_ch.duration       = o_dur_r;
  assign out_ch.average_speed  = o_avg_r;
  assign out_ch.top_speed      = o_top_r;
  assign out_ch.distance_reset = o_dist_r;
  assign out_ch.log_push       = o_log_r;

  // divide step
  assign rem_sh  = {1'b0, rem_r[14:0], dvd_r[rat_pkg::SUM_W-1]} | {rem_r[15], 16'd0};
  assign rem_sub = rem_sh - {1'b0, tick_r};
  assign q_bit   = (rem_sh >= {1'b0, tick_r});

  // scan step
  assign scan_en = ({1'b0, cnt_r} < (CNTW+1)'(WINDOW_LEN));
  assign win_sel = win_r[cnt_r[IDXW-1:0]];
  assign spread  = {1'b0, hi_r} - {1'b0, lo_r};

  // item decode, applied at the input transfer
  always_comb begin
    rat_pkg::speed_t   spd;
    logic              sval;
    logic              fresh;
    status_nxt    = status_r;
    tick_nxt      = tick_r;
    sum_nxt       = sum_r;
    avg_nxt       = avg_r;
    top_nxt       = top_r;
    idle_cnt_nxt  = idle_cnt_r;
    pause_cnt_nxt = pause_cnt_r;
    dist_nxt      = 1'b0;
    log_nxt       = 1'b0;
    run_nxt       = 1'b0;
    fresh         = 1'b0;
    spd           = in_ch.speed;
    sval          = in_ch.speed_valid;
    for (int i = 0; i < WINDOW_LEN; i++) win_nxt[i] = win_r[i];
    evict_nxt     = win_r[0];

    case (in_ch.kind)
      rat_pkg::KIND_TICK: begin
        if (status_r == rat_pkg::ST_NOT_STARTED && auto_start_r &&
            spd >= idle_speed_r && sval) begin
          fresh = 1'b1;
        end
        if (fresh) begin
          status_nxt = rat_pkg::ST_ACTIVE;
          tick_nxt   = '0;
          sum_nxt    = '0;
          avg_nxt    = '0;
          top_nxt    = '0;
          dist_nxt   = 1'b1;
          for (int i = 0; i < WINDOW_LEN; i++) win_nxt[i] = '0;
          evict_nxt  = '0;
        end
        if (status_nxt == rat_pkg::ST_ACTIVE || status_nxt == rat_pkg::ST_IDLE) begin
          if (tick_nxt < rat_pkg::DURATION_MAX) begin
            run_nxt  = 1'b1;
            tick_nxt = tick_nxt + 16'd1;
            sum_nxt  = sum_nxt + {16'd0, spd};
            for (int i = 0; i < WINDOW_LEN - 1; i++) win_nxt[i] = win_nxt[i+1];
            win_nxt[WINDOW_LEN-1] = spd;
            if (sval) begin
              if (spd < idle_speed_r && status_nxt == rat_pkg::ST_ACTIVE) begin
                idle_cnt_nxt = idle_cnt_nxt + 8'd1;
              end else if (spd >= idle_speed_r) begin
                status_nxt   = rat_pkg::ST_ACTIVE;
                idle_cnt_nxt = '0;
              end
              if (idle_cnt_nxt >= idle_timeout_r) status_nxt = rat_pkg::ST_IDLE;
            end
            if (status_nxt == rat_pkg::ST_IDLE && auto_pause_r) begin
              pause_cnt_nxt = pause_cnt_nxt + 8'd1;
              if (pause_cnt_nxt >= pause_timeout_r) status_nxt = rat_pkg::ST_PAUSED;
            end else begin
              pause_cnt_nxt = '0;
            end
          end else begin
            status_nxt = rat_pkg::ST_PAUSED;
          end
        end else if (status_nxt == rat_pkg::ST_PAUSED) begin
          if (spd >= idle_speed_r && auto_resume_r) begin
            pause_cnt_nxt = pause_cnt_nxt + 8'd1;
            if (pause_cnt_nxt >= resume_timeout_r) begin
              idle_cnt_nxt  = '0;
              pause_cnt_nxt = '0;
              status_nxt    = rat_pkg::ST_ACTIVE;
            end
          end else begin
            pause_cnt_nxt = '0;
          end
        end
      end
      rat_pkg::KIND_START: begin
        if (status_r == rat_pkg::ST_NOT_STARTED) begin
          status_nxt = rat_pkg::ST_ACTIVE;
          tick_nxt   = '0;
          sum_nxt    = '0;
          avg_nxt    = '0;
          top_nxt    = '0;
          dist_nxt   = 1'b1;
          for (int i = 0; i < WINDOW_LEN; i++) win_nxt[i] = '0;
        end else if (status_r == rat_pkg::ST_PAUSED) begin
          idle_cnt_nxt  = '0;
          pause_cnt_nxt = '0;
          status_nxt    = rat_pkg::ST_ACTIVE;
        end
      end
      rat_pkg::KIND_PAUSE: begin
        if (status_r == rat_pkg::ST_ACTIVE || status_r == rat_pkg::ST_IDLE) begin
          status_nxt = rat_pkg::ST_PAUSED;
        end
      end
      default: begin
        if (status_r != rat_pkg::ST_NOT_STARTED) begin
          log_nxt    = 1'b1;
          status_nxt = rat_pkg::ST_NOT_STARTED;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_start_r     <= 1'b0;
      auto_pause_r     <= 1'b0;
      auto_resume_r    <= 1'b0;
      idle_speed_r     <= '0;
      idle_timeout_r   <= '0;
      pause_timeout_r  <= '0;
      resume_timeout_r <= '0;
      top_delta_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rat_pkg::CFG_AUTO_START:     auto_start_r     <= cfg_data[0];
        rat_pkg::CFG_AUTO_PAUSE:     auto_pause_r     <= cfg_data[0];
        rat_pkg::CFG_AUTO_RESUME:    auto_resume_r    <= cfg_data[0];
        rat_pkg::CFG_IDLE_SPEED:     idle_speed_r     <= cfg_data[15:0];
        rat_pkg::CFG_IDLE_TIMEOUT:   idle_timeout_r   <= cfg_data[7:0];
        rat_pkg::CFG_PAUSE_TIMEOUT:  pause_timeout_r  <= cfg_data[7:0];
        rat_pkg::CFG_RESUME_TIMEOUT: resume_timeout_r <= cfg_data[7:0];
        rat_pkg::CFG_TOP_DELTA:      top_delta_r      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= S_IDLE;
      cnt_r       <= '0;
      status_r    <= rat_pkg::ST_NOT_STARTED;
      tick_r      <= '0;
      sum_r       <= '0;
      avg_r       <= '0;
      top_r       <= '0;
      idle_cnt_r  <= '0;
      pause_cnt_r <= '0;
      dist_r      <= 1'b0;
      log_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) win_r[i] <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
      case (seq_r)
        S_IDLE: begin
          if (in_xfer) begin
            status_r    <= status_nxt;
            tick_r      <= tick_nxt;
            sum_r       <= sum_nxt;
            avg_r       <= avg_nxt;
            top_r       <= top_nxt;
            idle_cnt_r  <= idle_cnt_nxt;
            pause_cnt_r <= pause_cnt_nxt;
            dist_r      <= dist_nxt;
            log_r       <= log_nxt;
            for (int i = 0; i < WINDOW_LEN; i++) win_r[i] <= win_nxt[i];
            cnt_r       <= '0;
            seq_r       <= run_nxt ? S_RUN : S_DONE;
          end
        end
        S_RUN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) seq_r <= S_FIN;
        end
        S_FIN: begin
          avg_r <= quo_r;
          if (spread <= {1'b0, top_delta_r} && hi_r > top_r) top_r <= hi_r;
          seq_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) seq_r <= S_IDLE;
        end
        default: seq_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers of the divider and scan
  always_ff @(posedge clk) begin
    if (seq_r == S_IDLE) begin
      dvd_r <= sum_nxt;
      rem_r <= '0;
      quo_r <= '0;
      hi_r  <= evict_nxt;
      lo_r  <= evict_nxt;
    end else if (seq_r == S_RUN) begin
      dvd_r <= {dvd_r[rat_pkg::SUM_W-2:0], 1'b0};
      rem_r <= q_bit ? rem_sub[15:0] : rem_sh[15:0];
      quo_r <= {quo_r[14:0], q_bit};
      if (scan_en) begin
        if (win_sel > hi_r) hi_r <= win_sel;
        if (win_sel < lo_r) lo_r <= win_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_state_r <= status_r;
      o_dur_r   <= tick_r;
      o_avg_r   <= avg_r;
      o_top_r   <= top_r;
      o_dist_r  <= dist_r;
      o_log_r   <= log_r;
    end
  end

  a_no_accept_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready)
    else $error("input accepted while an item is in work");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == S_RUN) |-> (tick_r != '0))
    else $error("divide step with zero duration");

  a_pulses_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(o_dist_r && o_log_r))
    else $error("distance reset and log push in one result");

  a_log_ends_ride: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_log_r) |-> (o_state_r == rat_pkg::ST_NOT_STARTED))
    else $error("log push with ride still running");

  a_run_reaches_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == S_RUN && cnt_r == CNT_LAST) |=> (seq_r == S_FIN))
    else $error("divide sequence did not finish");

endmodule
`default_nettype wire
